// ===== sv/wjs_pkg.sv =====
// shared types and constants for the weighted jacobi 3d stencil unit
package wjs_pkg;

    localparam int unsigned VAL_W        = 16;
    localparam int unsigned CFG_W        = 16;
    localparam int unsigned EDGE_IN_W    = 7;
    localparam int unsigned EDGE_MIN     = 4;
    localparam int unsigned WEIGHT_W     = 16;
    localparam int unsigned WEIGHT_ONE   = 32768;
    localparam int unsigned WEIGHT_RESET = 29491;
    localparam int unsigned GRID_RESET   = 64;
    localparam int unsigned COEF_W       = 18;
    localparam int unsigned DENOM        = 196608;
    localparam int unsigned DENOM_HALF   = 98304;
    localparam int unsigned SUM_W        = 19;
    localparam int unsigned NUM_W        = 36;
    localparam int unsigned T_W          = 20;
    // floor(t/3) == (t * ceil(2^21/3)) >> 21 for all t below 2^21
    localparam int unsigned RECIP3       = 699051;
    localparam int unsigned RECIP_SHIFT  = 21;
    localparam int unsigned Q_W          = 2 * T_W - RECIP_SHIFT;

    typedef enum logic {
        CFG_GRID_SIZE    = 1'b0,
        CFG_RELAX_WEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        TAP_CENTER = 3'd0,
        TAP_K_MINUS = 3'd1,
        TAP_K_PLUS  = 3'd2,
        TAP_J_MINUS = 3'd3,
        TAP_J_PLUS  = 3'd4,
        TAP_I_MINUS = 3'd5,
        TAP_I_PLUS  = 3'd6
    } t_tap;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETTLE0,
        S_SETTLE1,
        S_READ,
        S_READ_LAST,
        S_MUL,
        S_ADD,
        S_DIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_en;
        t_tap tap;
        logic mul;
        logic add;
        logic div;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic complete;
        logic out_free;
        logic emit_in_range;
    } t_stat;

endpackage

// ===== sv/wjs_ram.sv =====
// generic single-port ram with registered read
module wjs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8258
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/wjs_ctrl.sv =====
// sequencer: accepts words, steps the seven window reads and the arithmetic
module wjs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_cfg_we,
    input  wjs_pkg::t_stat i_stat,
    output logic          o_stall,
    output wjs_pkg::t_cmd o_cmd
);
    import wjs_pkg::*;

    t_state r_state, n_state;
    t_tap   r_tap, n_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= TAP_CENTER;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = i_cfg_we;
                if (i_cfg_we) begin
                    n_state = S_SETTLE0;
                end else if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.emit) begin
                        n_state = S_READ;
                        n_tap   = TAP_CENTER;
                    end
                end
            end
            // derived sizes settle while the sequencer waits in S_SETTLE0 and S_SETTLE1 after a register write
            S_SETTLE0: n_state = S_SETTLE1;
            S_SETTLE1: n_state = S_IDLE;
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.tap   = r_tap;
                if (r_tap == TAP_I_PLUS) begin
                    n_state = S_READ_LAST;
                end else begin
                    n_tap = t_tap'(r_tap + 3'd1);
                end
            end
            S_READ_LAST: n_state = S_MUL;
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== sv/wjs_datapath.sv =====
// counters, window store, weighted update arithmetic and output register
module wjs_datapath #(
    parameter int unsigned GRID_MAX = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [wjs_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [wjs_pkg::VAL_W-1:0]   i_point_value,
    input  logic                        i_is_flush,
    input  logic                        i_stall,
    input  wjs_pkg::t_cmd               i_cmd,
    output wjs_pkg::t_stat              o_stat,
    output logic                        o_valid,
    output logic [wjs_pkg::VAL_W-1:0]   o_new_value,
    output logic                        o_last_point
);
    import wjs_pkg::*;

    localparam int unsigned DEPTH = 2 * GRID_MAX * GRID_MAX + GRID_MAX + 2;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned NW    = $clog2(GRID_MAX + 1);
    localparam int unsigned CW    = $clog2(GRID_MAX * GRID_MAX * GRID_MAX + 1);
    localparam int unsigned GRID_DEF = (GRID_RESET > GRID_MAX) ? GRID_MAX : GRID_RESET;

    logic [NW-1:0]       r_grid;
    logic [WEIGHT_W-1:0] r_weight;
    logic [COEF_W-1:0]   r_coef;
    logic [2*NW-1:0]     r_nn;
    logic [CW-1:0]       r_total, r_delay;
    logic [CW-1:0]       r_recv, r_emit;
    logic [AW-1:0]       r_wp, r_ep;
    logic [NW-1:0]       r_ci, r_cj, r_ck;

    logic [3*NW-1:0]     w_total_full;
    logic [EDGE_IN_W-1:0] w_edge_in;
    logic [WEIGHT_W-1:0] w_weight_in;
    logic                w_complete, w_write, w_emit, w_end;

    assign w_total_full = r_nn * r_grid;
    assign w_edge_in    = i_cfg_data[EDGE_IN_W-1:0];
    assign w_weight_in  = i_cfg_data[WEIGHT_W-1:0];
    assign w_complete   = (r_recv >= r_total);
    assign w_write      = i_cmd.accept && !i_is_flush && !w_complete;
    assign w_emit       = (!i_is_flush && !w_complete) ? (r_recv >= r_delay)
                                                       : (w_complete && (r_emit < r_total));
    assign w_end        = ((r_emit + CW'(1)) >= r_total);

    // configuration and derived sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid   <= NW'(GRID_DEF);
            r_weight <= WEIGHT_W'(WEIGHT_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_GRID_SIZE) begin
                if (int'(w_edge_in) < EDGE_MIN) begin
                    r_grid <= NW'(EDGE_MIN);
                end else if (int'(w_edge_in) > GRID_MAX) begin
                    r_grid <= NW'(GRID_MAX);
                end else begin
                    r_grid <= NW'(w_edge_in);
                end
            end else begin
                r_weight <= (int'(w_weight_in) > WEIGHT_ONE) ? WEIGHT_W'(WEIGHT_ONE)
                                                              : w_weight_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= COEF_W'(DENOM - 6 * WEIGHT_RESET);
            r_nn    <= (2 * NW)'(GRID_DEF * GRID_DEF);
            r_total <= CW'(GRID_DEF * GRID_DEF * GRID_DEF);
            r_delay <= CW'(GRID_DEF * GRID_DEF + GRID_DEF + 1);
        end else begin
            r_coef  <= COEF_W'(DENOM) - (COEF_W'(r_weight) << 2) - (COEF_W'(r_weight) << 1);
            r_nn    <= r_grid * r_grid;
            r_total <= w_total_full[CW-1:0];
            r_delay <= CW'(r_nn) + CW'(r_grid) + CW'(1);
        end
    end

    // stream position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_we && i_cfg_index == CFG_GRID_SIZE)) begin
            r_recv <= '0;
            r_emit <= '0;
            r_wp   <= '0;
            r_ep   <= '0;
            r_ci   <= '0;
            r_cj   <= '0;
            r_ck   <= '0;
        end else if (i_cmd.load && w_end) begin
            r_recv <= '0;
            r_emit <= '0;
            r_wp   <= '0;
            r_ep   <= '0;
            r_ci   <= '0;
            r_cj   <= '0;
            r_ck   <= '0;
        end else begin
            if (w_write) begin
                r_recv <= r_recv + CW'(1);
                r_wp   <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_cmd.load) begin
                r_emit <= r_emit + CW'(1);
                r_ep   <= (r_ep == AW'(DEPTH - 1)) ? '0 : r_ep + AW'(1);
                if (r_ck == r_grid - NW'(1)) begin
                    r_ck <= '0;
                    if (r_cj == r_grid - NW'(1)) begin
                        r_cj <= '0;
                        r_ci <= r_ci + NW'(1);
                    end else begin
                        r_cj <= r_cj + NW'(1);
                    end
                end else begin
                    r_ck <= r_ck + NW'(1);
                end
            end
        end
    end

    // neighbour address, wrapped into the circular store
    logic [AW-1:0] w_off, w_rd_addr, w_addr;
    logic [AW:0]   w_up, w_dn;
    logic          w_minus;

    always_comb begin
        w_off   = '0;
        w_minus = 1'b0;
        unique case (i_cmd.tap)
            TAP_CENTER:  w_off = '0;
            TAP_K_MINUS: begin w_off = AW'(1);    w_minus = 1'b1; end
            TAP_K_PLUS:  w_off = AW'(1);
            TAP_J_MINUS: begin w_off = AW'(r_grid); w_minus = 1'b1; end
            TAP_J_PLUS:  w_off = AW'(r_grid);
            TAP_I_MINUS: begin w_off = AW'(r_nn); w_minus = 1'b1; end
            TAP_I_PLUS:  w_off = AW'(r_nn);
            default:     w_off = '0;
        endcase
        w_up = (AW + 1)'(r_ep) + (AW + 1)'(w_off);
        if (w_up >= (AW + 1)'(DEPTH)) begin
            w_up = w_up - (AW + 1)'(DEPTH);
        end
        w_dn = (AW + 1)'(r_ep) + (AW + 1)'(DEPTH) - (AW + 1)'(w_off);
        if (r_ep >= w_off) begin
            w_dn = (AW + 1)'(r_ep - w_off);
        end
        w_rd_addr = w_minus ? w_dn[AW-1:0] : w_up[AW-1:0];
    end

    assign w_addr = w_write ? r_wp : w_rd_addr;

    logic [VAL_W-1:0] w_rdata;

    wjs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_addr  (w_addr),
        .i_wdata (i_point_value),
        .o_rdata (w_rdata)
    );

    // gather center and neighbour sum as reads return
    logic             r_rd_v;
    t_tap             r_tap_d;
    logic [VAL_W-1:0] r_s;
    logic [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
        end
        r_tap_d <= i_cmd.tap;
        if (r_rd_v) begin
            if (r_tap_d == TAP_CENTER) begin
                r_s   <= w_rdata;
                r_sum <= '0;
            end else begin
                r_sum <= r_sum + SUM_W'(w_rdata);
            end
        end
    end

    // ((DENOM - 6w)*s + w*sum + DENOM/2) / DENOM, split as >>16 then /3
    logic [COEF_W+VAL_W-1:0]   r_p1;
    logic [WEIGHT_W+SUM_W-1:0] r_p2;
    logic [T_W-1:0]            r_t;
    logic [Q_W-1:0]            r_q;
    logic [NUM_W-1:0]          w_num;
    logic [2*T_W-1:0]          w_qf;

    assign w_num = NUM_W'(r_p1) + NUM_W'(r_p2) + NUM_W'(DENOM_HALF);
    assign w_qf  = r_t * T_W'(RECIP3);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p1 <= r_coef * r_s;
            r_p2 <= r_weight * r_sum;
        end
        if (i_cmd.add) begin
            r_t <= w_num[16 +: T_W];
        end
        if (i_cmd.div) begin
            r_q <= w_qf[RECIP_SHIFT +: Q_W];
        end
    end

    logic             w_interior;
    logic [VAL_W-1:0] w_result;

    assign w_interior = (r_ci != '0) && (r_ci < r_grid - NW'(1)) &&
                        (r_cj != '0) && (r_cj < r_grid - NW'(1)) &&
                        (r_ck != '0) && (r_ck < r_grid - NW'(1));
    assign w_result   = !w_interior ? r_s :
                        (r_q > Q_W'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} : r_q[VAL_W-1:0];

    // output word register
    logic             r_out_valid;
    logic [VAL_W-1:0] r_new;
    logic             r_last;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load) begin
            r_new  <= w_result;
            r_last <= (r_emit == r_total - CW'(1));
        end
    end

    assign o_valid      = r_out_valid;
    assign o_new_value  = r_new;
    assign o_last_point = r_last;

    assign o_stat.emit          = w_emit;
    assign o_stat.complete      = w_complete;
    assign o_stat.out_free      = w_out_free;
    assign o_stat.emit_in_range = (r_emit < r_total) && (r_emit <= r_recv);
endmodule

// ===== sv/weighted_jacobi_stencil_3d_unit.sv =====
// top level of the weighted jacobi 7-point 3d stencil unit
//
// input channel: i_valid / o_stall with i_point_value and i_is_flush. a grid of
// N*N*N points streams in raster order (k fastest); results leave in the same
// order on o_valid / i_stall with o_new_value and o_last_point, each result
// produced by the word that brings point e + N*N + N + 1. after the last point,
// flush words drain the remaining N*N + N + 1 results.
// a word that produces no result is accepted from idle without a stall. a word
// that produces a result stalls input while the seven window reads share the
// single port of the window ram, followed by multiply, add/round,
// divide-by-three multiply and output load in that order. the result sits in
// an output register, so the next word is accepted while it waits; a held
// output only delays the final load of the following result.
// configuration: i_cfg_we with i_cfg_index (0 grid size, 1 relax weight) and
// i_cfg_data; each write blocks input while sizes are derived.
// a grid size write restarts the grid.
// reset (synchronous, active low) clears counters and output valid and loads
// grid size 64 and weight 29491; the window ram is not cleared.
module weighted_jacobi_stencil_3d_unit #(
    parameter int unsigned GRID_MAX = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [wjs_pkg::VAL_W-1:0] i_point_value,
    input  logic                      i_is_flush,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [wjs_pkg::VAL_W-1:0] o_new_value,
    output logic                      o_last_point,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [wjs_pkg::CFG_W-1:0] i_cfg_data
);
    import wjs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    wjs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cfg_we (i_cfg_we),
        .i_stat   (w_stat),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    wjs_datapath #(
        .GRID_MAX (GRID_MAX)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_point_value (i_point_value),
        .i_is_flush    (i_is_flush),
        .i_stall       (i_stall),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_new_value   (o_new_value),
        .o_last_point  (o_last_point)
    );

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.emit_in_range)
        else $error("emit counter out of range");

    a_no_work_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_is_flush && !w_stat.complete |=> (!o_stall || i_cfg_we))
        else $error("early flush started work");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> w_stat.out_free)
        else $error("result loaded over a held word");
endmodule
